>>> sv/dlps_pkg.sv
// shared constants for the delay line pitch shifter
// hann half-window table used for the crossfade weight
// no dependencies
package dlps_pkg;

    localparam int DELAY_DEPTH = 8192;
    localparam int WIN_LEN     = 512;
    localparam int PTR_W       = 27;
    localparam int MIN_W       = 9;
    localparam int MIN_RESET   = 128;
    localparam int RATIO_MIN   = 8192;
    localparam int RATIO_MAX   = 32768;
    localparam int RATIO_ONE   = 16384;

    // round(32768 * (0.5 - 0.5 cos(pi k / 32))), k = 0..32
    function automatic logic [15:0] hann_entry(input logic [5:0] k);
        logic [15:0] v;
        case (k)
            6'd0:    v = 16'd0;
            6'd1:    v = 16'd79;
            6'd2:    v = 16'd315;
            6'd3:    v = 16'd705;
            6'd4:    v = 16'd1247;
            6'd5:    v = 16'd1935;
            6'd6:    v = 16'd2761;
            6'd7:    v = 16'd3719;
            6'd8:    v = 16'd4799;
            6'd9:    v = 16'd5990;
            6'd10:   v = 16'd7282;
            6'd11:   v = 16'd8661;
            6'd12:   v = 16'd10114;
            6'd13:   v = 16'd11628;
            6'd14:   v = 16'd13188;
            6'd15:   v = 16'd14778;
            6'd16:   v = 16'd16384;
            6'd17:   v = 16'd17990;
            6'd18:   v = 16'd19580;
            6'd19:   v = 16'd21140;
            6'd20:   v = 16'd22654;
            6'd21:   v = 16'd24107;
            6'd22:   v = 16'd25486;
            6'd23:   v = 16'd26778;
            6'd24:   v = 16'd27969;
            6'd25:   v = 16'd29049;
            6'd26:   v = 16'd30007;
            6'd27:   v = 16'd30833;
            6'd28:   v = 16'd31521;
            6'd29:   v = 16'd32063;
            6'd30:   v = 16'd32453;
            6'd31:   v = 16'd32689;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

endpackage

>>> sv/delay_line_pitch_shifter.sv
// top level of the delay line pitch shifter: delay store, sequencer, shared multiplier
// depends on dlps_pkg
//
// Each input transfer carries one Q1.15 sample and one Q2.14 pitch ratio and yields one
// crossfaded Q1.15 output sample. The block takes one item at a time: s_tready is high
// only while the sequencer is idle, and the result is registered once the sequencer is
// through and no earlier result still waits on m_tready; s_tready comes back with the
// same edge that registers the result. The Hann phase is a plain shift of the read pointer
// (the window length must be a power of two); the weight is interpolated unless the phase
// sits at the window center; each tap runs S_BASE, S_WRAP (again when its address wraps
// below zero), S_RD0, S_RD1 and S_TM0 to S_TM2; then come the crossfade S_MIX0 to S_MIX2
// and the pointer update S_PTR0 to S_PTR2, every product going in turn through one
// registered multiplier and the four tap samples through one store read port.
// The delay store needs no clearing pass after reset: entries not yet written since reset
// read as zero. The pointer floor is written through the cfg channel, which is always ready.
module delay_line_pitch_shifter #(
    parameter int DELAY_DEPTH = dlps_pkg::DELAY_DEPTH,
    parameter int WIN_LEN     = dlps_pkg::WIN_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] in_sample, [31:16] shift_ratio
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_sample
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [dlps_pkg::MIN_W-1:0] cfg_data  // read pointer floor in samples
);

    localparam int AW   = $clog2(DELAY_DEPTH);
    localparam int BW   = AW + 3;
    localparam int QW   = 12;
    localparam int LW   = $clog2(WIN_LEN);
    localparam int PW   = dlps_pkg::PTR_W + 2;
    localparam int MAW  = 34;
    localparam int MBW  = 18;
    localparam int ACW  = MAW + MBW;
    localparam logic signed [BW-1:0] DEPTH_B   = BW'(DELAY_DEPTH);
    localparam logic [QW-1:0]        HALF_WIN  = QW'(WIN_LEN / 2);
    localparam logic signed [PW-1:0] WIN_P     = PW'(WIN_LEN * 65536);
    localparam logic signed [PW-1:0] WIN2_P    = PW'(2 * WIN_LEN * 65536);
    localparam logic signed [ACW-1:0] ROUND_C  = ACW'(64'd1 << 30);

    typedef enum logic [4:0] {
        S_IDLE, S_PHASE, S_HWAIT, S_HSUM, S_BASE, S_WRAP, S_RD0, S_RD1,
        S_TM0, S_TM1, S_TM2, S_MIX0, S_MIX1, S_MIX2, S_PTR0, S_PTR1,
        S_PTR2, S_OUT
    } state_t;

    state_t state_reg;

    logic [dlps_pkg::MIN_W-1:0]  min_reg;
    logic [dlps_pkg::PTR_W-1:0]  ptr_reg;
    logic [AW-1:0]               wp_reg;
    logic                        wrapped_reg;
    logic signed [17:0]          step_reg;
    logic [15:0]                 frac_reg;
    logic [QW-1:0]               q1_reg;
    logic [15:0]                 lo_reg;
    logic [15:0]                 w_reg;
    logic                        tap_reg;
    logic signed [BW-1:0]        base_reg;
    logic signed [MAW-1:0]       s1_reg;
    logic signed [MAW-1:0]       mul_a_reg;
    logic signed [MBW-1:0]       mul_b_reg;
    logic signed [ACW-1:0]       prod_reg;
    logic signed [ACW-1:0]       acc_reg;
    logic signed [PW-1:0]        pn_reg;
    logic                        m_tvalid_reg;
    logic [15:0]                 m_tdata_reg;

    logic signed [15:0]          mem [DELAY_DEPTH];
    logic signed [15:0]          rdata_reg;
    logic                        rd_ok_reg;
    logic [AW-1:0]               rd_addr;
    logic                        mem_we;

    logic [15:0]          ratio_in;
    logic [15:0]          ratio_cl;
    logic [15:0]          neg_frac;
    logic [15:0]          phase_raw;
    logic [15:0]          ph;
    logic [5:0]           hk;
    logic [15:0]          hann_lo;
    logic [15:0]          hann_hi;
    logic signed [15:0]   x_data;
    logic [QW-1:0]        q_tap;
    logic signed [BW-1:0] base_p1;
    logic [AW-1:0]        addr1;
    logic signed [ACW-1:0] tap_sum;
    logic signed [20:0]   y_full;
    logic [15:0]          y_sat;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign mem_we    = s_tvalid && s_tready;

    always_comb begin
        ratio_in = s_tdata[31:16];
        if (ratio_in < 16'(dlps_pkg::RATIO_MIN)) begin
            ratio_cl = 16'(dlps_pkg::RATIO_MIN);
        end else if (ratio_in > 16'(dlps_pkg::RATIO_MAX)) begin
            ratio_cl = 16'(dlps_pkg::RATIO_MAX);
        end else begin
            ratio_cl = ratio_in;
        end
        neg_frac  = ~ptr_reg[15:0] + 16'd1;
        // phase within the window, Q0.16
        phase_raw = ptr_reg[LW+15:LW];
        ph        = (phase_raw > 16'd32768) ? (16'd0 - phase_raw) : phase_raw;
        hk        = ph[15:10];
        hann_lo   = dlps_pkg::hann_entry(hk);
        hann_hi   = dlps_pkg::hann_entry(hk + 6'd1);
        x_data    = rd_ok_reg ? rdata_reg : 16'sd0;
        q_tap     = tap_reg ? (q1_reg + HALF_WIN) : q1_reg;
        base_p1   = base_reg + BW'(1);
        addr1     = (base_p1 == DEPTH_B) ? '0 : base_p1[AW-1:0];
        rd_addr   = (state_reg == S_RD1) ? addr1 : base_reg[AW-1:0];
        tap_sum   = acc_reg + prod_reg;
        y_full    = acc_reg[ACW-1:31];
        if (y_full > 21'sd32767) begin
            y_sat = 16'h7fff;
        end else if (y_full < -21'sd32768) begin
            y_sat = 16'h8000;
        end else begin
            y_sat = y_full[15:0];
        end
    end

    // delay store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= s_tdata[15:0];
        end
        rdata_reg <= mem[rd_addr];
        rd_ok_reg <= wrapped_reg || (rd_addr <= wp_reg);
    end

    // shared multiplier, operands and product registered
    always_ff @(posedge aclk) begin
        prod_reg <= ACW'(mul_a_reg * mul_b_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            min_reg      <= dlps_pkg::MIN_W'(dlps_pkg::MIN_RESET);
            ptr_reg      <= dlps_pkg::PTR_W'(dlps_pkg::MIN_RESET * 65536);
            wp_reg       <= '0;
            wrapped_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                min_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (mem_we) begin
                        step_reg  <= 18'(($signed({2'b00, 16'(dlps_pkg::RATIO_ONE)})
                                     - $signed({2'b00, ratio_cl})) * 4);
                        frac_reg  <= neg_frac;
                        q1_reg    <= QW'(ptr_reg[dlps_pkg::PTR_W-1:16])
                                     + QW'(neg_frac != 16'd0);
                        tap_reg   <= 1'b0;
                        state_reg <= S_PHASE;
                    end
                end
                S_PHASE: begin
                    if (hk >= 6'd32) begin
                        w_reg     <= 16'd32768;
                        state_reg <= S_BASE;
                    end else begin
                        lo_reg    <= hann_lo;
                        mul_a_reg <= MAW'(hann_hi - hann_lo);
                        mul_b_reg <= MBW'(ph[9:0]);
                        state_reg <= S_HWAIT;
                    end
                end
                S_HWAIT: begin
                    state_reg <= S_HSUM;
                end
                S_HSUM: begin
                    w_reg     <= lo_reg + prod_reg[25:10];
                    state_reg <= S_BASE;
                end
                S_BASE: begin
                    base_reg  <= $signed({{(BW-AW){1'b0}}, wp_reg})
                                 - $signed({{(BW-QW){1'b0}}, q_tap});
                    state_reg <= S_WRAP;
                end
                S_WRAP: begin
                    if (base_reg < 0) begin
                        base_reg <= base_reg + DEPTH_B;
                    end else begin
                        state_reg <= S_RD0;
                    end
                end
                S_RD0: begin
                    state_reg <= S_RD1;
                end
                S_RD1: begin
                    mul_a_reg <= MAW'(x_data);
                    mul_b_reg <= MBW'(17'h10000 - {1'b0, frac_reg});
                    state_reg <= S_TM0;
                end
                S_TM0: begin
                    mul_a_reg <= MAW'(x_data);
                    mul_b_reg <= MBW'(frac_reg);
                    state_reg <= S_TM1;
                end
                S_TM1: begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_TM2;
                end
                S_TM2: begin
                    if (!tap_reg) begin
                        s1_reg    <= tap_sum[MAW-1:0];
                        tap_reg   <= 1'b1;
                        state_reg <= S_BASE;
                    end else begin
                        mul_a_reg <= tap_sum[MAW-1:0];
                        mul_b_reg <= MBW'(17'd32768 - {1'b0, w_reg});
                        state_reg <= S_MIX0;
                    end
                end
                S_MIX0: begin
                    mul_a_reg <= s1_reg;
                    mul_b_reg <= MBW'(w_reg);
                    state_reg <= S_MIX1;
                end
                // far tap product first, near tap product in the next cycle
                S_MIX1: begin
                    acc_reg   <= prod_reg + ROUND_C;
                    state_reg <= S_MIX2;
                end
                S_MIX2: begin
                    acc_reg   <= acc_reg + prod_reg;
                    state_reg <= S_PTR0;
                end
                S_PTR0: begin
                    pn_reg    <= $signed({2'b00, ptr_reg}) + PW'(step_reg);
                    state_reg <= S_PTR1;
                end
                S_PTR1: begin
                    if (pn_reg > WIN2_P) begin
                        pn_reg <= pn_reg - WIN_P;
                    end
                    state_reg <= S_PTR2;
                end
                S_PTR2: begin
                    if (pn_reg < $signed(PW'({min_reg, 16'h0000}))) begin
                        pn_reg <= pn_reg + WIN_P;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= y_sat;
                        ptr_reg      <= (pn_reg < 0) ? '0 : pn_reg[dlps_pkg::PTR_W-1:0];
                        if (wp_reg == AW'(DELAY_DEPTH - 1)) begin
                            wp_reg      <= '0;
                            wrapped_reg <= 1'b1;
                        end else begin
                            wp_reg <= wp_reg + AW'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
